// File: rtl/core/bhr_pkg.sv
package bhr_pkg;

  localparam int unsigned NUM_BUTTONS = 3;
  localparam int unsigned NUM_POTS    = 2;
  localparam int unsigned SAMPLE_BITS = 12;

  localparam int unsigned CFG_DATA_W  = 32;
  localparam int unsigned CFG_INDEX_W = 3;

  // register indexes of the configuration port
  localparam logic [CFG_INDEX_W-1:0] REG_EVENT_ENABLE  = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIMING_0 = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIMING_1 = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_HOLD_TIMING_2 = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_POT0_MIN_STEP = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_POT1_MIN_STEP = 3'd5;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] button_levels;
    logic [SAMPLE_BITS-1:0] pot0_sample;
    logic [SAMPLE_BITS-1:0] pot1_sample;
    logic [31:0]            now_ms;
  } in_item_t;

  typedef struct packed {
    logic [NUM_BUTTONS-1:0] press_events;
    logic [NUM_BUTTONS-1:0] hold_events;
    logic [NUM_POTS-1:0]    pot_change_events;
    logic [SAMPLE_BITS-1:0] pot0_value;
    logic [SAMPLE_BITS-1:0] pot1_value;
  } out_item_t;

  // per-button settings handed to a button lane
  typedef struct packed {
    logic        press_en;
    logic        hold_en;
    logic [15:0] hold_delay;
    logic [15:0] repeat_ivl;
  } btn_cfg_t;

  typedef struct packed {
    logic press_ev;
    logic hold_ev;
  } btn_ev_t;

endpackage

// File: rtl/core/bhr_button_lane.sv
module bhr_button_lane (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              fire_i,
  input  logic              level_i,
  input  logic [31:0]       now_i,
  input  bhr_pkg::btn_cfg_t cfg_i,
  output bhr_pkg::btn_ev_t  ev_o
);
  import bhr_pkg::*;

  logic        prev_q, prev_d;
  logic [31:0] deadline_q, deadline_d;
  logic        rise;
  logic [31:0] age;
  logic        passed;
  logic        hold;

  assign rise = level_i & ~prev_q;
  assign age  = now_i - deadline_q;

  // on the press edge the fresh deadline is now plus delay, which has passed
  // only for a zero delay
  assign passed = rise ? (cfg_i.hold_delay == 16'd0) : ~age[31];
  assign hold   = level_i & cfg_i.hold_en & passed;

  always_comb begin
    prev_d     = level_i;
    deadline_d = deadline_q;
    if (rise) begin
      deadline_d = now_i + {16'd0, cfg_i.hold_delay};
    end
    if (hold) begin
      deadline_d = now_i + {16'd0, cfg_i.repeat_ivl};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q     <= 1'b0;
      deadline_q <= '0;
    end else if (fire_i) begin
      prev_q     <= prev_d;
      deadline_q <= deadline_d;
    end
  end

  assign ev_o.press_ev = rise & cfg_i.press_en;
  assign ev_o.hold_ev  = hold;

endmodule

// File: rtl/core/bhr_pot_lane.sv
module bhr_pot_lane (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fire_i,
  input  logic                            en_i,
  input  logic [7:0]                      min_step_i,
  input  logic [bhr_pkg::SAMPLE_BITS-1:0] sample_i,
  output logic                            change_o,
  output logic [bhr_pkg::SAMPLE_BITS-1:0] value_o
);
  import bhr_pkg::*;

  logic [SAMPLE_BITS-1:0] value_q, value_d;
  logic [SAMPLE_BITS-1:0] diff;

  assign diff     = (sample_i >= value_q) ? (sample_i - value_q) : (value_q - sample_i);
  assign change_o = en_i & (diff >= SAMPLE_BITS'(min_step_i));
  assign value_d  = change_o ? sample_i : value_q;
  // value after this sample, registered by the merge stage
  assign value_o  = value_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      value_q <= '0;
    end else if (fire_i) begin
      value_q <= value_d;
    end
  end

endmodule

// File: rtl/core/button_hold_repeat_and_pot_deadband.sv
// Button press / hold auto-repeat and potentiometer dead-band block. Each input
// transaction is one polling sample (button levels, two pot readings, ms time)
// and yields exactly one output transaction with press, hold and pot change
// event bits plus the stored pot values. Every button and every pot has its own
// lane that works in the cycle the sample is accepted; a merge stage gathers the
// lane results into one output register. A sample is accepted every cycle, and
// its result appears in the next cycle; the only thing that holds off input is a
// result still waiting in the output register while the consumer is stalled.
// Hold deadlines compare wrap-aware against now_ms. Configuration is a plain
// write port and should be written only while the block is idle.
module button_hold_repeat_and_pot_deadband (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bhr_pkg::CFG_INDEX_W-1:0] cfg_index_i,
  input  logic [bhr_pkg::CFG_DATA_W-1:0]  cfg_wdata_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  bhr_pkg::in_item_t               in_data_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output bhr_pkg::out_item_t              out_data_o
);
  import bhr_pkg::*;

  logic [7:0]  event_enable_q;
  logic [31:0] hold_timing_q [NUM_BUTTONS];
  logic [7:0]  min_step_q    [NUM_POTS];

  logic      fire;
  logic      out_valid_q;
  out_item_t out_data_q, out_data_d;

  btn_cfg_t               btn_cfg [NUM_BUTTONS];
  btn_ev_t                btn_ev  [NUM_BUTTONS];
  logic [SAMPLE_BITS-1:0] pot_sample [NUM_POTS];
  logic [SAMPLE_BITS-1:0] pot_value  [NUM_POTS];
  logic [NUM_POTS-1:0]    pot_change;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      event_enable_q <= '0;
      for (int i = 0; i < NUM_BUTTONS; i++) hold_timing_q[i] <= '0;
      for (int j = 0; j < NUM_POTS; j++) min_step_q[j] <= '0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        REG_EVENT_ENABLE:  event_enable_q   <= cfg_wdata_i[7:0];
        REG_HOLD_TIMING_0: hold_timing_q[0] <= cfg_wdata_i;
        REG_HOLD_TIMING_1: hold_timing_q[1] <= cfg_wdata_i;
        REG_HOLD_TIMING_2: hold_timing_q[2] <= cfg_wdata_i;
        REG_POT0_MIN_STEP: min_step_q[0]    <= cfg_wdata_i[7:0];
        REG_POT1_MIN_STEP: min_step_q[1]    <= cfg_wdata_i[7:0];
        default: ;
      endcase
    end
  end

  assign in_ready_o = ~out_valid_q | out_ready_i;
  assign fire       = in_valid_i & in_ready_o;

  for (genvar i = 0; i < NUM_BUTTONS; i++) begin : g_btn
    assign btn_cfg[i].press_en   = event_enable_q[i];
    assign btn_cfg[i].hold_en    = event_enable_q[NUM_BUTTONS + i];
    assign btn_cfg[i].hold_delay = hold_timing_q[i][31:16];
    assign btn_cfg[i].repeat_ivl = hold_timing_q[i][15:0];

    bhr_button_lane u_lane (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .fire_i  (fire),
      .level_i (in_data_i.button_levels[i]),
      .now_i   (in_data_i.now_ms),
      .cfg_i   (btn_cfg[i]),
      .ev_o    (btn_ev[i])
    );
  end

  assign pot_sample[0] = in_data_i.pot0_sample;
  assign pot_sample[1] = in_data_i.pot1_sample;

  for (genvar j = 0; j < NUM_POTS; j++) begin : g_pot
    bhr_pot_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .fire_i     (fire),
      .en_i       (event_enable_q[2*NUM_BUTTONS + j]),
      .min_step_i (min_step_q[j]),
      .sample_i   (pot_sample[j]),
      .change_o   (pot_change[j]),
      .value_o    (pot_value[j])
    );
  end

  // merge lane results into one result item
  always_comb begin
    out_data_d = '0;
    for (int i = 0; i < NUM_BUTTONS; i++) begin
      out_data_d.press_events[i] = btn_ev[i].press_ev;
      out_data_d.hold_events[i]  = btn_ev[i].hold_ev;
    end
    out_data_d.pot_change_events = pot_change;
    out_data_d.pot0_value        = pot_value[0];
    out_data_d.pot1_value        = pot_value[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      out_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_data_q <= out_data_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_data_q;

endmodule

// File: rtl/core/bhr_checker.sv
module bhr_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            in_valid_i,
  input logic                            in_ready_o,
  input logic                            out_valid_o,
  input logic                            out_ready_i,
  input bhr_pkg::out_item_t              out_data_o
);
  import bhr_pkg::*;

  // every accepted sample shows up as a result in the next cycle
  a_in_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> out_valid_o)
    else $error("accepted sample gave no result");

  // input is held off only by a stalled result
  a_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_o && !out_ready_i)
    else $error("input stalled without a pending result");

  // a stalled result holds its payload
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

endmodule

bind button_hold_repeat_and_pot_deadband bhr_checker u_bhr_checker (.*);
